// ===== rtl/tlbf_pkg.sv =====
package tlbf_pkg;

    localparam int PidWidth   = 16;
    localparam int PageWidth  = 16;
    localparam int FrameWidth = 16;
    localparam int CountWidth = 32;
    localparam int LimitWidth = 5;
    localparam int AddrWidth  = 3;
    localparam int DataWidth  = 32;

    // register byte addresses
    localparam logic [AddrWidth-1:0] ADDR_ENABLE = 3'd0;
    localparam logic [AddrWidth-1:0] ADDR_LIMIT  = 3'd4;

    localparam logic                  ENABLE_RESET = 1'b1;
    localparam logic [LimitWidth-1:0] LIMIT_RESET  = 5'd16;

    // item kinds
    localparam logic KIND_ACCESS = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_COMPACT
    } t_state;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_APPEND,
        OP_EVICT_APPEND,
        OP_FLUSH_MARK,
        OP_COMPACT
    } t_cell_op;

    typedef struct packed {
        logic [PidWidth-1:0]   pid;
        logic [PageWidth-1:0]  page;
        logic [FrameWidth-1:0] frame;
    } t_entry;

    // broadcast to every cell of the row
    typedef struct packed {
        t_cell_op op;
        t_entry   entry;
    } t_cell_ctl;

endpackage

// ===== rtl/tlbf_cell.sv =====
module tlbf_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlbf_pkg::t_cell_ctl i_ctl,
    input  logic              i_prev_valid,
    input  logic              i_next_valid,
    input  tlbf_pkg::t_entry  i_next_entry,
    output logic              o_valid,
    output tlbf_pkg::t_entry  o_entry,
    output logic              o_match
);

    logic             r_valid;
    logic             n_valid;
    tlbf_pkg::t_entry r_entry;
    tlbf_pkg::t_entry n_entry;

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        case (i_ctl.op)
            tlbf_pkg::OP_APPEND: begin
                // first free slot takes the new translation
                if (!r_valid && i_prev_valid) begin
                    n_valid = 1'b1;
                    n_entry = i_ctl.entry;
                end
            end
            tlbf_pkg::OP_EVICT_APPEND: begin
                // whole row moves down one, tail takes the new translation
                if (r_valid) begin
                    n_entry = i_next_valid ? i_next_entry : i_ctl.entry;
                end
            end
            tlbf_pkg::OP_FLUSH_MARK: begin
                if (r_valid && (r_entry.pid == i_ctl.entry.pid)) begin
                    n_valid = 1'b0;
                end
            end
            tlbf_pkg::OP_COMPACT: begin
                // a hole pulls its upper neighbour down, holes rise
                if (!r_valid && i_next_valid) begin
                    n_valid = 1'b1;
                    n_entry = i_next_entry;
                end else if (r_valid && !i_prev_valid) begin
                    n_valid = 1'b0;
                end
            end
            default: begin
                n_valid = r_valid;
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;
    assign o_match = r_valid && (r_entry == i_ctl.entry);

endmodule

// ===== rtl/fifo_tlb_with_process_flush_core.sv =====
// translation buffer with oldest-first replacement and per-process flush
//
// input channel (i_in_valid / o_in_stall) carries one item per transfer:
// an access (page and frame lookup for a process) or a flush of a process.
// output channel (o_out_valid / i_out_stall) returns one result per item.
// configuration over the apb port: enable at 0x0, entry limit at 0x4.
//
// an access is looked up against every cell in the cycle it is taken and
// its result is registered, so it appears in the next cycle; accesses run at
// one per cycle while the receiver keeps up and no flush is in progress.
// a flush clears the matching cells in the cycle it is taken, then the row
// closes up: each hole rises by one cell a cycle until no valid cell sits
// above an empty one, and then the flush result is loaded; no item is
// taken meanwhile.
// while a result waits under stall, a new item is taken only in the cycle
// that result leaves; otherwise the input stalls as well.
// synchronous reset empties the buffer, clears both counters, enables the
// buffer and sets the limit to 16.
module fifo_tlb_with_process_flush_core #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_kind,
    input  logic [tlbf_pkg::PidWidth-1:0]      i_process_id,
    input  logic [tlbf_pkg::PageWidth-1:0]     i_page_number,
    input  logic [tlbf_pkg::FrameWidth-1:0]    i_frame_number,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_hit,
    output logic                               o_evicted,
    output logic [tlbf_pkg::PageWidth-1:0]     o_evicted_page,
    output logic [tlbf_pkg::CountWidth-1:0]    o_hit_total,
    output logic [tlbf_pkg::CountWidth-1:0]    o_access_total,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tlbf_pkg::AddrWidth-1:0]     paddr,
    input  logic [tlbf_pkg::DataWidth-1:0]     pwdata,
    output logic [tlbf_pkg::DataWidth-1:0]     prdata,
    output logic                               pready
);

    localparam int IdxWidth = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LimExt   = 7;

    // control state
    tlbf_pkg::t_state r_state;
    tlbf_pkg::t_state n_state;

    // configuration registers
    logic                              r_enable;
    logic [tlbf_pkg::LimitWidth-1:0]   r_limit;

    // counters
    logic [tlbf_pkg::CountWidth-1:0]   r_hit_cnt;
    logic [tlbf_pkg::CountWidth-1:0]   r_acc_cnt;

    // result register
    logic                              r_out_valid;
    logic                              r_hit;
    logic                              r_evicted;
    logic [tlbf_pkg::PageWidth-1:0]    r_ev_page;

    // row of cells
    logic                              w_valid [MAX_ENTRIES];
    tlbf_pkg::t_entry                  w_entry [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]            w_match;
    logic [MAX_ENTRIES-1:0]            w_hole;
    tlbf_pkg::t_cell_op                w_op;
    tlbf_pkg::t_cell_ctl               w_ctl;

    logic                              w_in_acc;
    logic                              w_cfg_wr;
    logic                              w_any_hit;
    logic                              w_holes;
    logic                              w_evict;
    logic [IdxWidth-1:0]               w_lim_idx;
    logic [LimExt-1:0]                 w_lim_ext;

    // datapath controls from the output block
    logic                              w_load;
    logic                              w_ld_hit;
    logic                              w_ld_evicted;
    logic                              w_cnt_access;
    logic                              w_cnt_hit;

    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // ------------------------------------------------------------------
    // cell row
    // ------------------------------------------------------------------
    assign w_ctl = '{op: w_op,
                     entry: '{pid: i_process_id, page: i_page_number,
                              frame: i_frame_number}};

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic             w_prev_valid;
        logic             w_next_valid;
        tlbf_pkg::t_entry w_next_entry;

        if (g == 0) begin : g_first
            // the oldest cell never moves down
            assign w_prev_valid = 1'b1;
        end else begin : g_mid
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == MAX_ENTRIES - 1) begin : g_last
            assign w_next_valid = 1'b0;
            assign w_next_entry = '0;
            assign w_hole[g]    = 1'b0;
        end else begin : g_inner
            assign w_next_valid = w_valid[g+1];
            assign w_next_entry = w_entry[g+1];
            assign w_hole[g]    = !w_valid[g] && w_valid[g+1];
        end

        tlbf_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_prev_valid (w_prev_valid),
            .i_next_valid (w_next_valid),
            .i_next_entry (w_next_entry),
            .o_valid      (w_valid[g]),
            .o_entry      (w_entry[g]),
            .o_match      (w_match[g])
        );
    end

    assign w_any_hit = |w_match;
    // a valid cell above an empty one means the row is not yet closed up
    assign w_holes   = |w_hole;

    // effective limit, clamped to 1..MAX_ENTRIES, as a cell index
    assign w_lim_ext = LimExt'(r_limit);

    always_comb begin
        if (w_lim_ext == '0) begin
            w_lim_idx = '0;
        end else if (w_lim_ext > LimExt'(MAX_ENTRIES)) begin
            w_lim_idx = IdxWidth'(MAX_ENTRIES - 1);
        end else begin
            w_lim_idx = IdxWidth'(w_lim_ext - LimExt'(1));
        end
    end

    // count has reached the limit when the limit's last cell is in use
    assign w_evict = w_valid[w_lim_idx];

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            tlbf_pkg::ST_IDLE: begin
                if (w_in_acc && (i_kind == tlbf_pkg::KIND_FLUSH)) begin
                    n_state = tlbf_pkg::ST_COMPACT;
                end
            end
            tlbf_pkg::ST_COMPACT: begin
                if (!w_holes) begin
                    n_state = tlbf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tlbf_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_in_stall   = 1'b1;
        w_op         = tlbf_pkg::OP_HOLD;
        w_load       = 1'b0;
        w_ld_hit     = 1'b0;
        w_ld_evicted = 1'b0;
        w_cnt_access = 1'b0;
        w_cnt_hit    = 1'b0;
        case (r_state)
            tlbf_pkg::ST_IDLE: begin
                // take an item when the result register is free or emptying
                o_in_stall = r_out_valid && i_out_stall;
                if (i_in_valid && !o_in_stall) begin
                    if (i_kind == tlbf_pkg::KIND_FLUSH) begin
                        w_op = tlbf_pkg::OP_FLUSH_MARK;
                    end else begin
                        w_load = 1'b1;
                        if (r_enable) begin
                            w_cnt_access = 1'b1;
                            if (w_any_hit) begin
                                w_ld_hit  = 1'b1;
                                w_cnt_hit = 1'b1;
                            end else if (w_evict) begin
                                w_ld_evicted = 1'b1;
                                w_op         = tlbf_pkg::OP_EVICT_APPEND;
                            end else begin
                                w_op = tlbf_pkg::OP_APPEND;
                            end
                        end
                    end
                end
            end
            tlbf_pkg::ST_COMPACT: begin
                if (w_holes) begin
                    w_op = tlbf_pkg::OP_COMPACT;
                end else begin
                    // row closed up: flush result
                    w_load = 1'b1;
                end
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlbf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // saturating counters
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt <= '0;
            r_acc_cnt <= '0;
        end else begin
            if (w_cnt_hit && (r_hit_cnt != '1)) begin
                r_hit_cnt <= r_hit_cnt + 1'b1;
            end
            if (w_cnt_access && (r_acc_cnt != '1)) begin
                r_acc_cnt <= r_acc_cnt + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_hit     <= w_ld_hit;
            r_evicted <= w_ld_evicted;
            // oldest cell holds the page that is pushed out
            r_ev_page <= w_ld_evicted ? w_entry[0].page : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_hit;
    assign o_evicted      = r_evicted;
    assign o_evicted_page = r_ev_page;
    // counters only move when a new result is loaded, so they match it
    assign o_hit_total    = r_hit_cnt;
    assign o_access_total = r_acc_cnt;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= tlbf_pkg::ENABLE_RESET;
            r_limit  <= tlbf_pkg::LIMIT_RESET;
        end else if (w_cfg_wr) begin
            case (paddr)
                tlbf_pkg::ADDR_ENABLE: r_enable <= pwdata[0];
                tlbf_pkg::ADDR_LIMIT:  r_limit  <= pwdata[tlbf_pkg::LimitWidth-1:0];
                default: begin
                    r_enable <= r_enable;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr)
            tlbf_pkg::ADDR_ENABLE: prdata = {{(tlbf_pkg::DataWidth-1){1'b0}}, r_enable};
            tlbf_pkg::ADDR_LIMIT:
                prdata = {{(tlbf_pkg::DataWidth-tlbf_pkg::LimitWidth){1'b0}}, r_limit};
            default: prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // the row is packed whenever items may be taken
    a_packed_when_idle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlbf_pkg::ST_IDLE) |-> !w_holes
    ) else $error("cell row has a hole while idle");

    // hits are a subset of counted accesses
    a_hits_bounded: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_hit_cnt <= r_acc_cnt
    ) else $error("hit count exceeds access count");

    // an access transfer yields its result in the next cycle
    a_access_latency: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_kind == tlbf_pkg::KIND_ACCESS)) |=> r_out_valid
    ) else $error("access result missing");

    // a hit never evicts
    a_hit_no_evict: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_hit && r_evicted)
    ) else $error("result flags both hit and eviction");

endmodule

// ===== tb/tb.sv =====
module tb;

    localparam int MaxEntries    = 16;
    // quiet margin after the last result before the registers change
    localparam int SettleCycles  = 2 * MaxEntries + 8;
    localparam int WatchdogLimit = 5000;
    localparam int PhaseItems    = 75;
    localparam int RandomPhases  = 8;
    localparam int ReportCap     = 200;
    localparam logic [tlbf_pkg::CountWidth-1:0] CountMax = '1;

    // one item of the input channel
    typedef struct packed {
        logic             kind;
        tlbf_pkg::t_entry entry;
    } t_request;

    // one item of the output channel
    typedef struct packed {
        logic                            hit;
        logic                            evicted;
        logic [tlbf_pkg::PageWidth-1:0]  evicted_page;
        logic [tlbf_pkg::CountWidth-1:0] hit_total;
        logic [tlbf_pkg::CountWidth-1:0] access_total;
    } t_outcome;

    // clock, reset and every block input start at known values
    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            i_in_valid     = 1'b0;
    logic                            i_kind         = tlbf_pkg::KIND_ACCESS;
    logic [tlbf_pkg::PidWidth-1:0]   i_process_id   = '0;
    logic [tlbf_pkg::PageWidth-1:0]  i_page_number  = '0;
    logic [tlbf_pkg::FrameWidth-1:0] i_frame_number = '0;
    logic                            i_out_stall    = 1'b0;
    logic                            psel           = 1'b0;
    logic                            penable        = 1'b0;
    logic                            pwrite         = 1'b0;
    logic [tlbf_pkg::AddrWidth-1:0]  paddr          = '0;
    logic [tlbf_pkg::DataWidth-1:0]  pwdata         = '0;

    logic                            o_in_stall;
    logic                            o_out_valid;
    logic                            o_hit;
    logic                            o_evicted;
    logic [tlbf_pkg::PageWidth-1:0]  o_evicted_page;
    logic [tlbf_pkg::CountWidth-1:0] o_hit_total;
    logic [tlbf_pkg::CountWidth-1:0] o_access_total;
    logic [tlbf_pkg::DataWidth-1:0]  prdata;
    logic                            pready;

    fifo_tlb_with_process_flush_core #(
        .MAX_ENTRIES(MaxEntries)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_process_id   (i_process_id),
        .i_page_number  (i_page_number),
        .i_frame_number (i_frame_number),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_evicted      (o_evicted),
        .o_evicted_page (o_evicted_page),
        .o_hit_total    (o_hit_total),
        .o_access_total (o_access_total),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial forever #1 i_clk = ~i_clk;

    // requests waiting for the driver, outcomes waiting for the output channel
    t_request pending_requests[$];
    t_outcome expected_outcomes[$];
    int       error_count = 0;

    // shadow copy of the translation row, oldest entry at index 0
    tlbf_pkg::t_entry                shadow_entries[MaxEntries];
    int                              shadow_count    = 0;
    logic [tlbf_pkg::CountWidth-1:0] shadow_hits     = '0;
    logic [tlbf_pkg::CountWidth-1:0] shadow_accesses = '0;
    logic                            cfg_enable      = tlbf_pkg::ENABLE_RESET;
    logic [tlbf_pkg::LimitWidth-1:0] cfg_limit       = tlbf_pkg::LIMIT_RESET;

    // recently issued translations, reissued to provoke hits
    tlbf_pkg::t_entry              recent_accesses[$];
    logic [tlbf_pkg::PidWidth-1:0] pid_pool[4] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0002};

    // apply one accepted request to the shadow row and queue its outcome
    function automatic void predict_translation(t_request req);
        t_outcome outc;
        int       live;
        int       lim;
        int       keep;
        logic     found;
        outc = '0;
        if (req.kind == tlbf_pkg::KIND_FLUSH) begin
            // drop every entry of the process, survivors keep their order
            keep = 0;
            for (int rd = 0; rd < shadow_count; rd++) begin
                if (shadow_entries[rd].pid != req.entry.pid) begin
                    shadow_entries[keep] = shadow_entries[rd];
                    keep++;
                end
            end
            shadow_count = keep;
        end else if (cfg_enable) begin
            found = 1'b0;
            for (int i = 0; i < shadow_count; i++)
                if (shadow_entries[i] == req.entry)
                    found = 1'b1;
            if (found) begin
                outc.hit = 1'b1;
                if (shadow_hits != CountMax)
                    shadow_hits++;
            end else begin
                // limit of zero acts as one, above the row size as the row size
                lim  = (cfg_limit == 0) ? 1 : (cfg_limit > MaxEntries) ? MaxEntries : cfg_limit;
                live = shadow_count;
                if (live >= lim && live > 0) begin
                    outc.evicted      = 1'b1;
                    outc.evicted_page = shadow_entries[0].page;
                    for (int i = 0; i + 1 < live; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    live--;
                end
                if (live < MaxEntries) begin
                    shadow_entries[live] = req.entry;
                    live++;
                end
                shadow_count = live;
            end
            if (shadow_accesses != CountMax)
                shadow_accesses++;
        end
        outc.hit_total    = shadow_hits;
        outc.access_total = shadow_accesses;
        expected_outcomes.push_back(outc);
    endfunction

    function automatic void compare_field(string field,
                                          logic [tlbf_pkg::CountWidth-1:0] want,
                                          logic [tlbf_pkg::CountWidth-1:0] got);
        if (want !== got) begin
            error_count++;
            // keep the log readable when the block is badly broken
            if (error_count <= ReportCap)
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        end
    endfunction

    function automatic void queue_request(logic kind, logic [tlbf_pkg::PidWidth-1:0] pid,
                                          logic [tlbf_pkg::PageWidth-1:0] page,
                                          logic [tlbf_pkg::FrameWidth-1:0] frame);
        t_request req;
        req.kind        = kind;
        req.entry.pid   = pid;
        req.entry.page  = page;
        req.entry.frame = frame;
        pending_requests.push_back(req);
    endfunction

    // mostly accesses over a small pool so that hits, evictions and flushes meet
    function automatic t_request random_request();
        t_request req;
        int       pick;
        pick            = $urandom_range(0, 99);
        req.kind        = tlbf_pkg::KIND_ACCESS;
        req.entry.pid   = pid_pool[$urandom_range(0, 3)];
        req.entry.page  = 16'($urandom_range(0, 7));
        req.entry.frame = 16'($urandom_range(0, 3));
        if (pick < 10) begin
            // page and frame are don't-care on a flush, so make them noise
            req.kind        = tlbf_pkg::KIND_FLUSH;
            req.entry.page  = 16'($urandom_range(0, 16'hFFFF));
            req.entry.frame = 16'($urandom_range(0, 16'hFFFF));
        end else if (pick < 45 && recent_accesses.size() != 0) begin
            req.entry = recent_accesses[$urandom_range(0, recent_accesses.size() - 1)];
        end else if (pick >= 90) begin
            req.entry.pid   = 16'($urandom_range(0, 16'hFFFF));
            req.entry.page  = 16'($urandom_range(0, 16'hFFFF));
            req.entry.frame = 16'($urandom_range(0, 16'hFFFF));
        end
        if (req.kind == tlbf_pkg::KIND_ACCESS) begin
            recent_accesses.push_back(req.entry);
            if (recent_accesses.size() > 24)
                void'(recent_accesses.pop_front());
        end
        return req;
    endfunction

    // apb write: setup cycle, then access cycle; register loads at the last edge
    task automatic write_register(input logic [tlbf_pkg::AddrWidth-1:0] addr,
                                  input logic [tlbf_pkg::DataWidth-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == tlbf_pkg::ADDR_ENABLE)
            cfg_enable = value[0];
        else
            cfg_limit = value[tlbf_pkg::LimitWidth-1:0];
    endtask

    // both registers, with noise in the unused upper bits
    task automatic configure(input logic enable,
                             input logic [tlbf_pkg::LimitWidth-1:0] limit);
        write_register(tlbf_pkg::ADDR_ENABLE, (($urandom() >> 1) << 1)
                       | {{(tlbf_pkg::DataWidth-1){1'b0}}, enable});
        write_register(tlbf_pkg::ADDR_LIMIT,
                       (($urandom() >> tlbf_pkg::LimitWidth) << tlbf_pkg::LimitWidth)
                       | {{(tlbf_pkg::DataWidth-tlbf_pkg::LimitWidth){1'b0}}, limit});
    endtask

    // block is idle once nothing waits on either side and any flush has closed up
    task automatic wait_for_drain();
        while (pending_requests.size() != 0 || i_in_valid || expected_outcomes.size() != 0)
            @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    // driver: bursts of transfers separated by random gaps, now and then a long run
    t_request offered_req;
    int       burst_left = 0;
    int       gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // transfer completes at this edge, so the block now owns the request
            if (i_in_valid && !o_in_stall)
                predict_translation(offered_req);
            // a stalled request stays on the pins untouched
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    offered_req    = pending_requests.pop_front();
                    i_in_valid     <= 1'b1;
                    i_kind         <= offered_req.kind;
                    i_process_id   <= offered_req.entry.pid;
                    i_page_number  <= offered_req.entry.page;
                    i_frame_number <= offered_req.entry.frame;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if ($urandom_range(0, 3) == 0) begin
                        burst_left = $urandom_range(40, 120);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver: check each transfer, stall on a pattern that changes mode
    int stall_mode  = 0;
    int cycle_count = 0;

    always @(posedge i_clk) begin
        t_outcome seen;
        t_outcome want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                seen = '{o_hit, o_evicted, o_evicted_page, o_hit_total, o_access_total};
                if (expected_outcomes.size() == 0) begin
                    error_count++;
                    $display("%0t: result with none expected, expected nothing actual %p",
                             $time, seen);
                end else begin
                    want = expected_outcomes.pop_front();
                    compare_field("hit", 32'(want.hit), 32'(seen.hit));
                    compare_field("evicted", 32'(want.evicted), 32'(seen.evicted));
                    compare_field("evicted_page", 32'(want.evicted_page),
                                  32'(seen.evicted_page));
                    compare_field("hit_total", want.hit_total, seen.hit_total);
                    compare_field("access_total", want.access_total, seen.access_total);
                end
            end
            cycle_count++;
            if (cycle_count % 256 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                2:       i_out_stall <= ($urandom_range(0, 9) < 6);
                default: i_out_stall <= ((cycle_count % 7) < 3);
            endcase
        end
    end

    // watchdog: too long without any transfer or register access means a hang
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic                            phase_enable;
        logic [tlbf_pkg::LimitWidth-1:0] phase_limit;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: hit and miss at the field extremes, flushes, then a full row
        queue_request(tlbf_pkg::KIND_ACCESS, 16'h0000, 16'h0000, 16'h0000);
        queue_request(tlbf_pkg::KIND_ACCESS, 16'h0000, 16'h0000, 16'h0000);
        queue_request(tlbf_pkg::KIND_ACCESS, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_request(tlbf_pkg::KIND_ACCESS, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // near misses: only one field differs
        queue_request(tlbf_pkg::KIND_ACCESS, 16'h0000, 16'hFFFF, 16'h0000);
        queue_request(tlbf_pkg::KIND_ACCESS, 16'h0000, 16'h0000, 16'hFFFF);
        queue_request(tlbf_pkg::KIND_FLUSH, 16'h0000, 16'hA5A5, 16'h5A5A);
        // flush of a process with nothing stored
        queue_request(tlbf_pkg::KIND_FLUSH, 16'h1234, 16'h0000, 16'h0000);
        for (int p = 1; p <= 15; p++)
            queue_request(tlbf_pkg::KIND_ACCESS, 16'h0001, 16'(p), 16'(p));
        // row is full, so this miss must evict
        queue_request(tlbf_pkg::KIND_ACCESS, 16'h0002, 16'h8000, 16'h5555);
        wait_for_drain();

        // limit dropped below the live count: misses evict one and keep the count
        configure(1'b1, 5'd4);
        queue_request(tlbf_pkg::KIND_ACCESS, 16'h0003, 16'h7FFF, 16'hAAAA);
        queue_request(tlbf_pkg::KIND_ACCESS, 16'h0001, 16'h000F, 16'h000F);
        // long flush: most of the row belongs to this process
        queue_request(tlbf_pkg::KIND_FLUSH, 16'h0001, 16'hFFFF, 16'hFFFF);
        wait_for_drain();

        // bypassed: accesses leave state and counters alone, flush still acts
        configure(1'b0, 5'd4);
        queue_request(tlbf_pkg::KIND_ACCESS, 16'h0002, 16'h8000, 16'h5555);
        queue_request(tlbf_pkg::KIND_FLUSH, 16'h0002, 16'h0000, 16'h0000);
        wait_for_drain();

        // limit of zero behaves as one
        configure(1'b1, 5'd0);
        queue_request(tlbf_pkg::KIND_ACCESS, 16'h0004, 16'h0001, 16'h0001);
        queue_request(tlbf_pkg::KIND_ACCESS, 16'h0004, 16'h0002, 16'h0002);
        wait_for_drain();

        for (int phase = 0; phase < RandomPhases; phase++) begin
            phase_enable = 1'b1;
            case (phase)
                0:       phase_limit = 5'd16;
                1:       phase_limit = 5'd1;
                2:       phase_limit = 5'd31;
                3:       phase_limit = 5'd0;
                4:       phase_limit = 5'd8;
                5: begin
                    phase_enable = 1'b0;
                    phase_limit  = 5'($urandom_range(0, 31));
                end
                6:       phase_limit = 5'd2;
                default: phase_limit = 5'($urandom_range(0, 31));
            endcase
            configure(phase_enable, phase_limit);
            pid_pool[2] = 16'($urandom_range(0, 16'hFFFF));
            pid_pool[3] = 16'($urandom_range(0, 16'hFFFF));
            for (int n = 0; n < PhaseItems; n++) begin
                pending_requests.push_back(random_request());
                // hold the sender mid-phase until every outcome is back
                if (phase == 4 && n == PhaseItems / 2)
                    wait_for_drain();
            end
            wait_for_drain();
        end

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
